// File: design/tssm_pkg.sv
// Shared codes, state encoding and controller/datapath interface types for the three-stack unit.
package tssm_pkg;

   localparam logic [1:0] CMD_PUSH = 2'd0;
   localparam logic [1:0] CMD_POP  = 2'd1;
   localparam logic [1:0] CMD_PEEK = 2'd2;

   localparam logic [1:0] SEL_A = 2'd0;
   localparam logic [1:0] SEL_B = 2'd1;
   localparam logic [1:0] SEL_C = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam int REQ_DATA_WIDTH = 32;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SHIFT
   } state_type;

   typedef struct packed {
      logic accept;
      logic execute;
      logic start_shift;
      logic copy_step;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic pending;
      logic out_free;
      logic need_shift;
      logic copy_done;
   } dp_status_type;

endpackage

// File: design/tssm_ctrl.sv
// Request sequencer: accept, execute, and B-relocation control for the three-stack unit.
module tssm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tssm_pkg::dp_status_type dp_status,
   output tssm_pkg::dp_cmd_type    dp_cmd
);

   tssm_pkg::state_type state_ff;
   tssm_pkg::state_type state_in;
   logic                allow;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tssm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      dp_cmd    = '0;
      req_stall = 1'b1;
      allow     = !dp_status.pending || dp_status.out_free;
      case (state_ff)
         tssm_pkg::ST_IDLE: begin
            dp_cmd.load_rsp = dp_status.pending && dp_status.out_free;
            req_stall       = !allow;
            dp_cmd.accept   = req_valid && allow;
            if (dp_cmd.accept) begin
               state_in = tssm_pkg::ST_EXEC;
            end
         end
         tssm_pkg::ST_EXEC: begin
            if (dp_status.need_shift) begin
               dp_cmd.start_shift = 1'b1;
               state_in           = tssm_pkg::ST_SHIFT;
            end else begin
               dp_cmd.execute = 1'b1;
               state_in       = tssm_pkg::ST_IDLE;
            end
         end
         tssm_pkg::ST_SHIFT: begin
            dp_cmd.copy_step = 1'b1;
            if (dp_status.copy_done) begin
               state_in = tssm_pkg::ST_EXEC;
            end
         end
         default: begin
            state_in = tssm_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: design/tssm_datapath.sv
// Stack memory, stack pointers, B-relocation copy engine and response register.
module tssm_datapath #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tssm_pkg::dp_cmd_type    dp_cmd,
   output tssm_pkg::dp_status_type dp_status,
   input  logic [1:0]             req_command,
   input  logic [1:0]             req_stack_select,
   input  logic [31:0]            req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [31:0]            rsp_top_value,
   output logic [1:0]             rsp_status,
   output logic                   rsp_empty_a,
   output logic                   rsp_empty_b,
   output logic                   rsp_empty_c,
   output logic                   rsp_all_full
);

   localparam int AW = $clog2(DEPTH);
   localparam int PW = $clog2(DEPTH + 1);
   localparam int SW = (DATA_WIDTH < tssm_pkg::REQ_DATA_WIDTH) ? DATA_WIDTH
                                                               : tssm_pkg::REQ_DATA_WIDTH;
   localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);
   localparam logic [PW-1:0] HALF_P  = PW'(DEPTH / 2);
   localparam logic [PW-1:0] ONE_P   = PW'(1);

   // stack storage
   logic [SW-1:0] mem_ff [DEPTH];
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [SW-1:0] mem_wdata;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;
   logic [SW-1:0] rd_data_ff;

   // latched request
   logic [1:0]    cmd_ff;
   logic [1:0]    sel_ff;
   logic [SW-1:0] value_ff;

   // pointers
   logic [PW-1:0] a_count_ff, a_count_in;
   logic [PW-1:0] b_end_ff, b_end_in;
   logic [PW-1:0] b_count_ff, b_count_in;
   logic [PW-1:0] c_start_ff, c_start_in;

   // copy engine
   logic [AW-1:0] src_ff, src_in;
   logic [AW-1:0] dst_ff, dst_in;
   logic [PW-1:0] cnt_ff, cnt_in;
   logic          up_ff, up_in;
   logic          wr_pend_ff, wr_pend_in;
   logic [AW-1:0] wr_addr_ff, wr_addr_in;

   // pending result and response register
   logic          pending_ff;
   logic [1:0]    res_status_ff;
   logic          res_read_ff;
   logic          rsp_valid_ff;
   logic [31:0]   rsp_top_value_ff;
   logic [1:0]    rsp_status_ff;
   logic          rsp_empty_a_ff;
   logic          rsp_empty_b_ff;
   logic          rsp_empty_c_ff;
   logic          rsp_all_full_ff;

   logic [PW-1:0] b_begin;
   logic          a_touch_b;
   logic          b_touch_c;
   logic          full;
   logic          req_ok;
   logic          is_push;
   logic          is_read;
   logic          sel_empty;
   logic          up_dir;
   logic [PW:0]   gap_up;
   logic [PW:0]   gap_dn;
   logic [PW-1:0] shift_dist;
   logic [1:0]    exec_status;
   logic          do_push;
   logic          do_read;
   logic          do_pop;
   logic          copy_read;
   logic [PW-1:0] push_addr;
   logic [PW-1:0] read_addr;
   logic [PW-1:0] b_end_dec;

   assign b_begin   = b_end_ff - b_count_ff;
   assign a_touch_b = a_count_ff == b_begin;
   assign b_touch_c = c_start_ff == b_end_ff;
   assign full      = a_touch_b && b_touch_c;
   assign b_end_dec = b_end_ff - ONE_P;

   assign req_ok  = (cmd_ff == tssm_pkg::CMD_PUSH || cmd_ff == tssm_pkg::CMD_POP ||
                     cmd_ff == tssm_pkg::CMD_PEEK) &&
                    (sel_ff == tssm_pkg::SEL_A || sel_ff == tssm_pkg::SEL_B ||
                     sel_ff == tssm_pkg::SEL_C);
   assign is_push = req_ok && cmd_ff == tssm_pkg::CMD_PUSH;
   assign is_read = req_ok && cmd_ff != tssm_pkg::CMD_PUSH;
   assign up_dir  = sel_ff == tssm_pkg::SEL_A;

   always_comb begin
      case (sel_ff)
         tssm_pkg::SEL_A: begin
            sel_empty = a_count_ff == '0;
            push_addr = a_count_ff;
            read_addr = a_count_ff - ONE_P;
         end
         tssm_pkg::SEL_B: begin
            sel_empty = b_count_ff == '0;
            push_addr = b_end_ff;
            read_addr = b_end_dec;
         end
         default: begin
            sel_empty = c_start_ff == DEPTH_P;
            push_addr = c_start_ff - ONE_P;
            read_addr = c_start_ff;
         end
      endcase
   end

   // half of the gap on the far side of B, rounded up
   assign gap_up     = {1'b0, c_start_ff} - {1'b0, b_end_ff} + (PW+1)'(1);
   assign gap_dn     = {1'b0, b_begin} - {1'b0, a_count_ff} + (PW+1)'(1);
   assign shift_dist = up_dir ? gap_up[PW:1] : gap_dn[PW:1];

   assign exec_status = (is_push && full)      ? tssm_pkg::STATUS_FULL  :
                        (is_read && sel_empty) ? tssm_pkg::STATUS_EMPTY :
                                                 tssm_pkg::STATUS_OK;
   assign do_push   = dp_cmd.execute && is_push && !full;
   assign do_read   = dp_cmd.execute && is_read && !sel_empty;
   assign do_pop    = do_read && cmd_ff == tssm_pkg::CMD_POP;
   assign copy_read = dp_cmd.copy_step && cnt_ff != '0;

   assign dp_status.pending    = pending_ff;
   assign dp_status.out_free   = !rsp_valid_ff || !rsp_stall;
   assign dp_status.need_shift = is_push && !full &&
                                 (up_dir ? a_touch_b : b_touch_c);
   assign dp_status.copy_done  = cnt_ff == '0 && !wr_pend_ff;

   // memory ports
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = wr_addr_ff;
      mem_wdata = rd_data_ff;
      if (wr_pend_ff) begin
         mem_we = 1'b1;
      end else if (do_push) begin
         mem_we    = 1'b1;
         mem_waddr = push_addr[AW-1:0];
         mem_wdata = value_ff;
      end
      mem_re    = do_read || copy_read;
      mem_raddr = copy_read ? src_ff : read_addr[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem_ff[mem_raddr];
      end
   end

   // pointer and copy engine next state
   always_comb begin
      a_count_in = a_count_ff;
      b_end_in   = b_end_ff;
      b_count_in = b_count_ff;
      c_start_in = c_start_ff;
      src_in     = src_ff;
      dst_in     = dst_ff;
      cnt_in     = cnt_ff;
      up_in      = up_ff;
      wr_pend_in = 1'b0;
      wr_addr_in = wr_addr_ff;
      if (dp_cmd.start_shift) begin
         up_in  = up_dir;
         cnt_in = b_count_ff;
         if (up_dir) begin
            b_end_in = b_end_ff + shift_dist;
            src_in   = b_end_dec[AW-1:0];
            dst_in   = AW'(b_end_dec + shift_dist);
         end else begin
            b_end_in = b_end_ff - shift_dist;
            src_in   = b_begin[AW-1:0];
            dst_in   = AW'(b_begin - shift_dist);
         end
      end
      if (copy_read) begin
         cnt_in     = cnt_ff - ONE_P;
         wr_pend_in = 1'b1;
         wr_addr_in = dst_ff;
         if (up_ff) begin
            src_in = src_ff - AW'(1);
            dst_in = dst_ff - AW'(1);
         end else begin
            src_in = src_ff + AW'(1);
            dst_in = dst_ff + AW'(1);
         end
      end
      if (do_push) begin
         case (sel_ff)
            tssm_pkg::SEL_A: begin
               a_count_in = a_count_ff + ONE_P;
            end
            tssm_pkg::SEL_B: begin
               b_end_in   = b_end_ff + ONE_P;
               b_count_in = b_count_ff + ONE_P;
            end
            default: begin
               c_start_in = c_start_ff - ONE_P;
            end
         endcase
      end
      if (do_pop) begin
         case (sel_ff)
            tssm_pkg::SEL_A: begin
               a_count_in = a_count_ff - ONE_P;
            end
            tssm_pkg::SEL_B: begin
               b_end_in   = b_end_dec;
               b_count_in = b_count_ff - ONE_P;
            end
            default: begin
               c_start_in = c_start_ff + ONE_P;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_count_ff <= '0;
         b_end_ff   <= HALF_P;
         b_count_ff <= '0;
         c_start_ff <= DEPTH_P;
         cnt_ff     <= '0;
         wr_pend_ff <= 1'b0;
         pending_ff <= 1'b0;
      end else begin
         a_count_ff <= a_count_in;
         b_end_ff   <= b_end_in;
         b_count_ff <= b_count_in;
         c_start_ff <= c_start_in;
         cnt_ff     <= cnt_in;
         wr_pend_ff <= wr_pend_in;
         if (dp_cmd.execute) begin
            pending_ff <= 1'b1;
         end else if (dp_cmd.load_rsp) begin
            pending_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      src_ff     <= src_in;
      dst_ff     <= dst_in;
      up_ff      <= up_in;
      wr_addr_ff <= wr_addr_in;
      if (dp_cmd.accept) begin
         cmd_ff   <= req_command;
         sel_ff   <= req_stack_select;
         value_ff <= req_value[SW-1:0];
      end
      if (dp_cmd.execute) begin
         res_status_ff <= exec_status;
         res_read_ff   <= do_read;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dp_cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load_rsp) begin
         rsp_top_value_ff <= res_read_ff ? 32'(rd_data_ff) : '0;
         rsp_status_ff    <= res_status_ff;
         rsp_empty_a_ff   <= a_count_ff == '0;
         rsp_empty_b_ff   <= b_count_ff == '0;
         rsp_empty_c_ff   <= c_start_ff == DEPTH_P;
         rsp_all_full_ff  <= full;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_top_value = rsp_top_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_empty_a   = rsp_empty_a_ff;
   assign rsp_empty_b   = rsp_empty_b_ff;
   assign rsp_empty_c   = rsp_empty_c_ff;
   assign rsp_all_full  = rsp_all_full_ff;

endmodule

// File: design/three_stacks_shared_memory_unit.sv
// Top level: three stacks in one shared memory, controller plus datapath.
//
//   channel   ports                                   direction
//   req       valid/stall, command, stack_select,     in
//             value
//   rsp       valid/stall, top_value, status,         out
//             empty_a/b/c, all_full
//
// A push, pop or peek is first latched, then performs its single memory access;
// the result is presented from an output register.
// A push that must relocate stack B first copies B one word per cycle through
// the memory's separate read and write ports.
// Synchronous reset empties all stacks; stack memory is not cleared.
// While a result waits on rsp_stall and another result is pending, further requests are stalled.
module three_stacks_shared_memory_unit #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [1:0]  req_stack_select,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_top_value,
   output logic [1:0]  rsp_status,
   output logic        rsp_empty_a,
   output logic        rsp_empty_b,
   output logic        rsp_empty_c,
   output logic        rsp_all_full
);

   tssm_pkg::dp_cmd_type    dp_cmd;
   tssm_pkg::dp_status_type dp_status;

   tssm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   tssm_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .dp_cmd           (dp_cmd),
      .dp_status        (dp_status),
      .req_command      (req_command),
      .req_stack_select (req_stack_select),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_top_value    (rsp_top_value),
      .rsp_status       (rsp_status),
      .rsp_empty_a      (rsp_empty_a),
      .rsp_empty_b      (rsp_empty_b),
      .rsp_empty_c      (rsp_empty_c),
      .rsp_all_full     (rsp_all_full)
   );

endmodule
